### src/mfpe_pkg.sv
`timescale 1ns / 1ps

package mfpe_pkg;

  // default sizing
  localparam int MAX_BALLS_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;

  // field widths
  localparam int COORD_W = 32;
  localparam int STEP_W  = 31;
  localparam int PIX_W   = 12;

  // world position: origin plus index times step
  localparam int PROD_W = PIX_W + STEP_W;
  localparam int HX_W   = PROD_W + 2;
  localparam int DX_W   = HX_W + 1;

  // stream and config port widths
  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 2'd3;

  localparam logic [STEP_W-1:0] STEP_RESET = 31'd65536;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  localparam logic [OUT_DATA_W-1:0] PIX_MAX = 8'hFF;

  typedef struct packed {
    logic load_point;
    logic start_eval;
    logic set_origin;
    logic rd_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic rd_last;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

### src/mfpe_ctrl.sv
`timescale 1ns / 1ps

module mfpe_ctrl import mfpe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_action_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ORG   = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_action_i == ACT_EVAL) begin
            cmd_o.start_eval = 1'b1;
            state_d          = ST_ORG;
          end else begin
            cmd_o.load_point = 1'b1;
          end
        end
      end
      ST_ORG: begin
        cmd_o.set_origin = 1'b1;
        state_d          = status_i.count_zero ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.rd_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/mfpe_datapath.sv
`timescale 1ns / 1ps

module mfpe_datapath import mfpe_pkg::*; #(
  parameter int MAX_BALLS = MAX_BALLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  new_frame_i,
  input  logic [COORD_W-1:0]    point_x_i,
  input  logic [COORD_W-1:0]    point_y_i,
  input  logic [PIX_W-1:0]      pixel_col_i,
  input  logic [PIX_W-1:0]      pixel_row_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] pixel_value_o,
  output logic                  saturated_o
);

  localparam int CNT_W  = $clog2(MAX_BALLS + 1);
  localparam int ADDR_W = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
  localparam int SQ_W   = 2 * FRAC_BITS;
  localparam int ONE_W  = SQ_W + 1;
  localparam int ACC_W  = ONE_W + CNT_W;
  localparam int SCL_W  = ONE_W + 8;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BALLS);
  localparam logic [ONE_W-1:0] ONE_Q2  = ONE_W'(1) << SQ_W;
  localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1) << SQ_W;

  // configuration registers
  logic [COORD_W-1:0] x_origin_q, y_origin_q;
  logic [STEP_W-1:0]  x_step_q, y_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= '0;
      x_step_q   <= STEP_RESET;
      y_origin_q <= '0;
      y_step_q   <= STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_X_ORIGIN: x_origin_q <= cfg_data_i;
        REG_X_STEP:   x_step_q   <= cfg_data_i[STEP_W-1:0];
        REG_Y_ORIGIN: y_origin_q <= cfg_data_i;
        REG_Y_STEP:   y_step_q   <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // point store and fill count
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   rd_idx_q;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [COORD_W-1:0] mem_x [MAX_BALLS];
  logic [COORD_W-1:0] mem_y [MAX_BALLS];
  logic [COORD_W-1:0] bx_q, by_q;

  assign wr_en   = cmd_i.load_point & (new_frame_i | (count_q < CNT_MAX));
  assign wr_addr = new_frame_i ? '0 : count_q[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load_point) begin
      if (new_frame_i) begin
        count_q <= CNT_W'(1);
      end else if (count_q < CNT_MAX) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[wr_addr] <= point_x_i;
      mem_y[wr_addr] <= point_y_i;
    end
    if (cmd_i.rd_en) begin
      bx_q <= mem_x[rd_idx_q[ADDR_W-1:0]];
      by_q <= mem_y[rd_idx_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
    end else if (cmd_i.set_origin) begin
      rd_idx_q <= '0;
    end else if (cmd_i.rd_en) begin
      rd_idx_q <= rd_idx_q + CNT_W'(1);
    end
  end

  // pixel position in world coordinates
  logic [PROD_W-1:0] px_q, py_q;
  logic [HX_W-1:0]   hx_q, hy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_eval) begin
      px_q <= PROD_W'(pixel_col_i) * PROD_W'(x_step_q);
      py_q <= PROD_W'(pixel_row_i) * PROD_W'(y_step_q);
    end
    if (cmd_i.set_origin) begin
      hx_q <= {{(HX_W-COORD_W){x_origin_q[COORD_W-1]}}, x_origin_q} + {2'b00, px_q};
      hy_q <= {{(HX_W-COORD_W){y_origin_q[COORD_W-1]}}, y_origin_q} + {2'b00, py_q};
    end
  end

  // per-ball pipeline: read, distance, square, accumulate
  logic v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  logic [DX_W-1:0]      dx, dy, adx, ady;
  logic                 near;
  logic [FRAC_BITS-1:0] dxm_q, dym_q;
  logic                 near2_q, near3_q;
  logic [SQ_W-1:0]      sqx, sqy;
  logic [ONE_W-1:0]     sq_q;
  logic [ONE_W-1:0]     term;
  logic [ACC_W-1:0]     acc_q;

  assign dx   = {hx_q[HX_W-1], hx_q} - {{(DX_W-COORD_W){bx_q[COORD_W-1]}}, bx_q};
  assign dy   = {hy_q[HX_W-1], hy_q} - {{(DX_W-COORD_W){by_q[COORD_W-1]}}, by_q};
  assign adx  = dx[DX_W-1] ? (~dx + DX_W'(1)) : dx;
  assign ady  = dy[DX_W-1] ? (~dy + DX_W'(1)) : dy;
  // both offsets strictly inside one unit
  assign near = (adx[DX_W-1:FRAC_BITS] == '0) && (ady[DX_W-1:FRAC_BITS] == '0);

  assign sqx = SQ_W'(dxm_q) * SQ_W'(dxm_q);
  assign sqy = SQ_W'(dym_q) * SQ_W'(dym_q);

  assign term = (near3_q && (sq_q < ONE_Q2)) ? (ONE_Q2 - sq_q) : '0;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      dxm_q   <= adx[FRAC_BITS-1:0];
      dym_q   <= ady[FRAC_BITS-1:0];
      near2_q <= near;
    end
    if (v2_q) begin
      sq_q    <= ONE_W'(sqx) + ONE_W'(sqy);
      near3_q <= near2_q;
    end
    if (cmd_i.set_origin) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + ACC_W'(term);
    end
  end

  // scale by 255 and saturate
  logic                  sat;
  logic [SCL_W-1:0]      scl;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] pix_q;
  logic                  sat_q;

  assign sat = acc_q > ACC_ONE;
  assign scl = {acc_q[ONE_W-1:0], 8'b0} - SCL_W'(acc_q[ONE_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pix_q <= sat ? PIX_MAX : scl[SQ_W+7:SQ_W];
      sat_q <= sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pix_q;
  assign saturated_o   = sat_q;

  assign status_o.count_zero = (count_q == '0);
  assign status_o.rd_last    = ((rd_idx_q + CNT_W'(1)) == count_q);
  assign status_o.pipe_busy  = v1_q | v2_q | v3_q;
  assign status_o.out_free   = ~out_valid_q | out_ready_i;

endmodule

### src/metaball_field_pixel_eval.sv
`timescale 1ns / 1ps

// metaball field evaluator, one pixel at a time
// s_axis: a word is either a point load (tuser[0] = 0) or a pixel
//   evaluation (tuser[0] = 1); tuser[1] on a load empties the point store
//   before the point is written; a load into a full store is dropped
// m_axis: one word per evaluation, pixel value in tdata, saturation in tuser
// cfg: write-only register port, always ready; index 0 x origin, 1 x step,
//   2 y origin, 3 y step; write only while no evaluation is in flight
// a load keeps the block idle and the next word can follow at once
// an evaluation offers its word after these steps: the step multiply runs
//   at the accepting edge, then the origin add, one store read per stored
//   point, a drain until the three pipeline stages are seen empty, and the
//   load of the output register; an empty store skips reads and drain
// the next word is taken in the cycle after the output load; the single
//   read port of the point store means the points are read one at a time
// the block takes no new word while an evaluation runs; a result waiting
//   in the output register does not block loads or the next evaluation,
//   only the hand-off of that evaluation's result
// reset empties the point store (contents stay undefined, count zero),
//   sets origins to 0.0 and steps to 1.0 (at the default FRAC_BITS) and clears the output valid
module metaball_field_pixel_eval import mfpe_pkg::*; #(
  parameter int MAX_BALLS = MAX_BALLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // point_x [31:0], point_y [63:32], pixel_col [75:64], pixel_row [87:76]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action [0], new_frame [1]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_value [7:0]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // saturated [0]
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;
  logic    saturated;

  // registers always take a write in the cycle it is offered
  assign cfg_ready_o = 1'b1;

  mfpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser[0]),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mfpe_datapath #(
    .MAX_BALLS (MAX_BALLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .new_frame_i   (s_axis_tuser[1]),
    .point_x_i     (s_axis_tdata[31:0]),
    .point_y_i     (s_axis_tdata[63:32]),
    .pixel_col_i   (s_axis_tdata[75:64]),
    .pixel_row_i   (s_axis_tdata[87:76]),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .pixel_value_o (m_axis_tdata),
    .saturated_o   (saturated)
  );

  assign m_axis_tuser = saturated;

endmodule

### src/mfpe_checker.sv
`timescale 1ns / 1ps

module mfpe_checker import mfpe_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_USER_W-1:0]  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  // stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // saturation always comes with full scale
  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == PIX_MAX)
    else $error("saturated word below full scale");

  // an accepted evaluation blocks the input
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ACT_EVAL) |=> !s_axis_tready)
    else $error("input open during evaluation");

  // a load leaves the input ready
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ACT_LOAD) |=> s_axis_tready)
    else $error("input stalled after a load");

endmodule

bind metaball_field_pixel_eval mfpe_checker u_mfpe_checker (.*);
